FILE: rtl/gbei_pkg.sv
// Shared types, register offsets and helpers for the GPIO bank with edge and level interrupts.
`default_nettype none

package gbei_pkg;

	// Number of pins the bank is built for
	localparam int unsigned NUM_PINS  = 32;
	localparam int unsigned PIN_W     = 32;
	localparam int unsigned ADDR_W    = 9;
	localparam int unsigned CNT_W     = 6;

	// Request kinds
	typedef enum logic [1:0] {
		CMD_READ  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_TICK  = 2'd2
	} cmd_t;

	// Register byte offsets
	localparam logic [ADDR_W-1:0] OFS_STATUS   = 9'h02c;
	localparam logic [ADDR_W-1:0] OFS_EN_SET   = 9'h034;
	localparam logic [ADDR_W-1:0] OFS_EN_CLR   = 9'h03c;
	localparam logic [ADDR_W-1:0] OFS_CTRL     = 9'h130;
	localparam logic [ADDR_W-1:0] OFS_OE       = 9'h134;
	localparam logic [ADDR_W-1:0] OFS_DIN      = 9'h138;
	localparam logic [ADDR_W-1:0] OFS_DOUT     = 9'h13c;
	localparam logic [ADDR_W-1:0] OFS_LVL_LOW  = 9'h140;
	localparam logic [ADDR_W-1:0] OFS_LVL_HIGH = 9'h144;
	localparam logic [ADDR_W-1:0] OFS_RISE     = 9'h148;
	localparam logic [ADDR_W-1:0] OFS_FALL     = 9'h14c;
	localparam logic [ADDR_W-1:0] OFS_DOUT_CLR = 9'h190;
	localparam logic [ADDR_W-1:0] OFS_DOUT_SET = 9'h194;

	// One request as it enters the bank
	typedef struct packed {
		cmd_t              cmd;
		logic [ADDR_W-1:0] addr;
		logic [PIN_W-1:0]  wdata;
		logic [PIN_W-1:0]  pad_in;
	} item_t;

	// One response
	typedef struct packed {
		logic [PIN_W-1:0] rdata;
		logic [PIN_W-1:0] pad_out;
		logic [PIN_W-1:0] pad_oe_n;
		logic             irq;
	} result_t;

	// Mask of implemented pins; zero counts as one pin, large values saturate
	function automatic logic [PIN_W-1:0] implemented_pins(input logic [CNT_W-1:0] pins);
		logic [CNT_W-1:0] n;
		n = pins;
		if (n == '0) begin
			n = CNT_W'(1);
		end
		if (n > CNT_W'(NUM_PINS)) begin
			n = CNT_W'(NUM_PINS);
		end
		// a shift of the full width or more yields zero, so all pins stay set
		return ~({PIN_W{1'b1}} << n);
	endfunction

endpackage

`default_nettype wire

FILE: rtl/gbei_core.sv
// Register file, pad sample tick and interrupt status of the GPIO bank.
`default_nettype none

module gbei_core (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                item_valid,
	input  gbei_pkg::item_t                    item,
	input  wire  [gbei_pkg::CNT_W-1:0]         pins_present,
	output gbei_pkg::result_t                  result
);
	import gbei_pkg::*;

	logic [PIN_W-1:0] data_out_q, output_disable_q, rise_detect_q, fall_detect_q;
	logic [PIN_W-1:0] level_high_q, level_low_q, irq_enable_q, irq_status_q, data_in_q;
	logic             module_disable_q;

	logic [PIN_W-1:0] data_out_d, output_disable_d, rise_detect_d, fall_detect_d;
	logic [PIN_W-1:0] level_high_d, level_low_d, irq_enable_d, irq_status_d, data_in_d;
	logic             module_disable_d;

	logic [PIN_W-1:0] pm;
	logic [PIN_W-1:0] rd_val;
	logic [PIN_W-1:0] ev;
	logic             is_read, is_write, is_tick;

	assign pm       = implemented_pins(pins_present);
	assign is_read  = item_valid && (item.cmd == CMD_READ);
	assign is_write = item_valid && (item.cmd == CMD_WRITE);
	assign is_tick  = item_valid && (item.cmd == CMD_TICK) && !module_disable_q;

	// Read mux, masked to implemented pins
	always_comb begin
		case (item.addr)
			OFS_STATUS:   rd_val = irq_status_q & irq_enable_q & pm;
			OFS_EN_SET:   rd_val = irq_enable_q & pm;
			OFS_EN_CLR:   rd_val = irq_enable_q & pm;
			OFS_CTRL:     rd_val = {{(PIN_W-1){1'b0}}, module_disable_q};
			OFS_OE:       rd_val = output_disable_q & pm;
			OFS_DIN:      rd_val = data_in_q & pm;
			OFS_DOUT:     rd_val = data_out_q & pm;
			OFS_DOUT_CLR: rd_val = data_out_q & pm;
			OFS_DOUT_SET: rd_val = data_out_q & pm;
			OFS_LVL_LOW:  rd_val = level_low_q & pm;
			OFS_LVL_HIGH: rd_val = level_high_q & pm;
			OFS_RISE:     rd_val = rise_detect_q & pm;
			OFS_FALL:     rd_val = fall_detect_q & pm;
			default:      rd_val = '0;
		endcase
	end

	// Edge and level events seen on this tick
	assign ev = (((item.pad_in & ~data_in_q) & rise_detect_q)
		| ((~item.pad_in & data_in_q) & fall_detect_q)
		| (item.pad_in & level_high_q)
		| (~item.pad_in & level_low_q)) & pm;

	// Next state
	always_comb begin
		data_out_d       = data_out_q;
		output_disable_d = output_disable_q;
		rise_detect_d    = rise_detect_q;
		fall_detect_d    = fall_detect_q;
		level_high_d     = level_high_q;
		level_low_d      = level_low_q;
		irq_enable_d     = irq_enable_q;
		irq_status_d     = irq_status_q;
		data_in_d        = data_in_q;
		module_disable_d = module_disable_q;
		if (is_write) begin
			case (item.addr)
				OFS_STATUS:   irq_status_d     = irq_status_q & ~item.wdata;
				OFS_EN_SET:   irq_enable_d     = irq_enable_q | item.wdata;
				OFS_EN_CLR:   irq_enable_d     = irq_enable_q & ~item.wdata;
				OFS_CTRL:     module_disable_d = item.wdata[0];
				OFS_OE:       output_disable_d = item.wdata;
				OFS_DOUT:     data_out_d       = item.wdata;
				OFS_LVL_LOW:  level_low_d      = item.wdata;
				OFS_LVL_HIGH: level_high_d     = item.wdata;
				OFS_RISE:     rise_detect_d    = item.wdata;
				OFS_FALL:     fall_detect_d    = item.wdata;
				OFS_DOUT_CLR: data_out_d       = data_out_q & ~item.wdata;
				OFS_DOUT_SET: data_out_d       = data_out_q | item.wdata;
				default:      ;
			endcase
		end
		if (is_tick) begin
			irq_status_d = irq_status_q | ev;
			data_in_d    = item.pad_in;
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_out_q       <= '0;
			output_disable_q <= '1;
			rise_detect_q    <= '0;
			fall_detect_q    <= '0;
			level_high_q     <= '0;
			level_low_q      <= '0;
			irq_enable_q     <= '0;
			irq_status_q     <= '0;
			data_in_q        <= '0;
			module_disable_q <= 1'b0;
		end else begin
			data_out_q       <= data_out_d;
			output_disable_q <= output_disable_d;
			rise_detect_q    <= rise_detect_d;
			fall_detect_q    <= fall_detect_d;
			level_high_q     <= level_high_d;
			level_low_q      <= level_low_d;
			irq_enable_q     <= irq_enable_d;
			irq_status_q     <= irq_status_d;
			data_in_q        <= data_in_d;
			module_disable_q <= module_disable_d;
		end
	end

	// Response reflects state after this request
	assign result.rdata    = is_read ? rd_val : '0;
	assign result.pad_out  = data_out_d & pm;
	assign result.pad_oe_n = output_disable_d | ~pm;
	assign result.irq      = |(irq_status_d & irq_enable_d & pm);

`ifndef ASSERT_OFF
	// Status bits rise only on an enabled tick
	a_status_only_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		!is_tick |=> ((irq_status_q & ~$past(irq_status_q)) == '0))
		else $error("status bit set without a tick");

	// A disabled bank ignores ticks
	a_disabled_tick_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item.cmd == CMD_TICK && module_disable_q)
		|=> ($stable(data_in_q) && $stable(irq_status_q)))
		else $error("tick changed state while disabled");

	// A read leaves all state alone
	a_read_no_side_effect: assert property (@(posedge clk) disable iff (!arst_n)
		is_read |=> ($stable(data_out_q) && $stable(output_disable_q)
			&& $stable(irq_enable_q) && $stable(irq_status_q)))
		else $error("read changed state");
`endif

endmodule

`default_nettype wire

FILE: rtl/gpio_bank_with_edge_level_irq_top.sv
// Top level of the 32-pin GPIO bank: stream ports, input stage, response register.
// Datapath: a request waits in the input stage register, passes through the core and
// is captured in the response register. Throughput: one request per cycle while
// m_axis_tready drains responses; the input stage takes one more request while a
// response waits; all updates are one bitwise pass. Reset: arst_n asynchronously
// resets all registers but item_s1 and result_s2; output disable resets to all ones.
`default_nettype none

module gpio_bank_with_edge_level_irq_top (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_axis_tvalid,
	output logic         s_axis_tready,
	input  wire  [79:0]  s_axis_tdata,  // addr[8:0], wdata[40:9], pad_in[72:41], zero
	input  wire  [1:0]   s_axis_tuser,  // cmd[1:0]
	output logic         m_axis_tvalid,
	input  wire          m_axis_tready,
	output logic [103:0] m_axis_tdata,  // rdata[31:0], pad_out[63:32], pad_oe_n[95:64],
	                                    // irq[96], zero
	input  wire          cfg_valid,
	output logic         cfg_ready,
	input  wire  [5:0]   cfg_data       // pins_present
);
	import gbei_pkg::*;

	logic                 s1_valid_q;
	item_t                item_s1;
	result_t              result_s2;
	result_t              core_result;
	logic                 s1_move;
	logic [CNT_W-1:0]     pins_present_q;
	item_t                in_item;

	// Unpack the incoming request
	assign in_item.cmd    = cmd_t'(s_axis_tuser);
	assign in_item.addr   = s_axis_tdata[8:0];
	assign in_item.wdata  = s_axis_tdata[40:9];
	assign in_item.pad_in = s_axis_tdata[72:41];

	// Handshake: input stage advances when the response register is free or drained
	assign s1_move       = s1_valid_q && (!m_axis_tvalid || m_axis_tready);
	assign s_axis_tready = !s1_valid_q || s1_move;
	assign cfg_ready     = 1'b1;

	// Pin count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pins_present_q <= CNT_W'(NUM_PINS);
		end else if (cfg_valid) begin
			pins_present_q <= cfg_data;
		end
	end

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			s1_valid_q <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1 <= in_item;
		end
	end

	gbei_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (s1_move),
		.item         (item_s1),
		.pins_present (pins_present_q),
		.result       (core_result)
	);

	// Response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (s1_move) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			result_s2 <= core_result;
		end
	end

	// Pack the response
	assign m_axis_tdata = {7'd0, result_s2.irq, result_s2.pad_oe_n,
		result_s2.pad_out, result_s2.rdata};

endmodule

`default_nettype wire
